/* rtl/complex_arithmetic_unit_macros.svh */
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared concurrent assertion helpers with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Types, constants and helpers shared by the pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 24;
    localparam int TOL_W     = 31;
    localparam int DIV_STEPS = DATA_W;
    localparam int FEED_W    = DATA_W - FRAC_W;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd17;
    localparam logic [2:0] REG_TOL_IDX = 3'd0;

    localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [64:0] SAT_LO = -65'sd2147483648;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_NEG   = 3'd4,
        CMD_EQ    = 3'd5,
        CMD_SCALE = 3'd6
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } sat_t;

    // products and short sums from the first stage
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] p_ac;
        logic signed [63:0] p_bd;
        logic signed [63:0] p_ad;
        logic signed [63:0] p_bc;
        logic signed [63:0] p_cc;
        logic signed [63:0] p_dd;
        logic signed [32:0] sum_r;
        logic signed [32:0] sum_i;
        logic signed [32:0] dif_r;
        logic signed [32:0] dif_i;
        logic signed [32:0] neg_r;
        logic signed [32:0] neg_i;
    } s1_t;

    // per-item control and finished non-divide results
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] rr;
        logic signed [31:0] ri;
        logic               eq;
        logic               ovf;
        logic               dz;
        logic               neg_r;
        logic               neg_i;
        logic               big_r;
        logic               big_i;
    } side_t;

    // restoring divider working set for both parts
    typedef struct packed {
        logic [63:0]        den;
        logic [63:0]        rem_r;
        logic [63:0]        rem_i;
        logic [FEED_W-1:0]  feed_r;
        logic [FEED_W-1:0]  feed_i;
        logic [31:0]        q_r;
        logic [31:0]        q_i;
    } divw_t;

    function automatic sat_t sat65(input logic signed [64:0] v);
        sat_t s;
        s.ovf = 1'b0;
        s.val = v[31:0];
        if (v > SAT_HI) begin
            s.val = WORD_MAX;
            s.ovf = 1'b1;
        end else if (v < SAT_LO) begin
            s.val = WORD_MIN;
            s.ovf = 1'b1;
        end
        return s;
    endfunction

    function automatic logic signed [64:0] ext33(input logic signed [32:0] v);
        return {{32{v[32]}}, v};
    endfunction

endpackage

/* rtl/cau_mul_stage.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit multiply stage
// Registers the six operand products and the short sums, differences and negations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_mul_stage import cau_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] a_real,
    input  logic signed [31:0] a_imag,
    input  logic signed [31:0] b_real,
    input  logic signed [31:0] b_imag,
    output logic               out_valid,
    input  logic               out_ready,
    output s1_t                out_data
);

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    always_comb begin
        data_next.cmd   = cmd;
        data_next.p_ac  = a_real * b_real;
        data_next.p_bd  = a_imag * b_imag;
        data_next.p_ad  = a_real * b_imag;
        data_next.p_bc  = a_imag * b_real;
        data_next.p_cc  = b_real * b_real;
        data_next.p_dd  = b_imag * b_imag;
        data_next.sum_r = {a_real[31], a_real} + {b_real[31], b_real};
        data_next.sum_i = {a_imag[31], a_imag} + {b_imag[31], b_imag};
        data_next.dif_r = {a_real[31], a_real} - {b_real[31], b_real};
        data_next.dif_i = {a_imag[31], a_imag} - {b_imag[31], b_imag};
        data_next.neg_r = 33'sd0 - {a_real[31], a_real};
        data_next.neg_i = 33'sd0 - {a_imag[31], a_imag};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/cau_prep.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit prepare stages
// Finishes the non-divide commands and sets up the quotient divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_prep import cau_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [TOL_W-1:0] tol,
    input  logic             in_valid,
    output logic             in_ready,
    input  s1_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output side_t            out_side,
    output divw_t            out_div
);

    function automatic logic signed [64:0] p_ext(input logic signed [63:0] v);
        return {v[63], v};
    endfunction

    // stage A: combine products, saturate
    logic               a_valid_reg;
    logic               a_ready;
    side_t              a_side_reg, a_side_next;
    logic [63:0]        a_den_reg, a_den_next;
    logic signed [64:0] a_nr_reg, a_nr_next;
    logic signed [64:0] a_ni_reg, a_ni_next;

    logic signed [64:0] mul_re, mul_im, scl_re, scl_im;
    logic signed [32:0] tol_s;
    sat_t               sr, si;

    always_comb begin
        mul_re = (p_ext(in_data.p_ac) - p_ext(in_data.p_bd)) >>> FRAC_W;
        mul_im = (p_ext(in_data.p_ad) + p_ext(in_data.p_bc)) >>> FRAC_W;
        scl_re = p_ext(in_data.p_ac) >>> FRAC_W;
        scl_im = p_ext(in_data.p_bc) >>> FRAC_W;
        tol_s  = {2'b00, tol};

        sr = '0;
        si = '0;
        a_side_next = '0;
        a_side_next.cmd = in_data.cmd;
        unique case (in_data.cmd)
            CMD_ADD: begin
                sr = sat65(ext33(in_data.sum_r));
                si = sat65(ext33(in_data.sum_i));
            end
            CMD_SUB: begin
                sr = sat65(ext33(in_data.dif_r));
                si = sat65(ext33(in_data.dif_i));
            end
            CMD_MUL: begin
                sr = sat65(mul_re);
                si = sat65(mul_im);
            end
            CMD_NEG: begin
                sr = sat65(ext33(in_data.neg_r));
                si = sat65(ext33(in_data.neg_i));
            end
            CMD_SCALE: begin
                sr = sat65(scl_re);
                si = sat65(scl_im);
            end
            CMD_EQ: begin
                a_side_next.eq = (in_data.dif_r <= tol_s) && (in_data.dif_r >= -tol_s)
                              && (in_data.dif_i <= tol_s) && (in_data.dif_i >= -tol_s);
            end
            default: begin
            end
        endcase
        a_side_next.rr  = sr.val;
        a_side_next.ri  = si.val;
        a_side_next.ovf = sr.ovf || si.ovf;

        a_den_next = in_data.p_cc + in_data.p_dd;
        a_nr_next  = p_ext(in_data.p_ac) + p_ext(in_data.p_bd);
        a_ni_next  = p_ext(in_data.p_bc) - p_ext(in_data.p_ad);
    end

    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            a_side_reg <= a_side_next;
            a_den_reg  <= a_den_next;
            a_nr_reg   <= a_nr_next;
            a_ni_reg   <= a_ni_next;
        end
    end

    // stage B: magnitudes, range check, divider seed
    logic        b_valid_reg;
    side_t       b_side_reg, b_side_next;
    divw_t       b_div_reg, b_div_next;
    logic [63:0] mag_r, mag_i;
    logic [64:0] nr_abs, ni_abs;

    always_comb begin
        nr_abs = a_nr_reg[64] ? 65'(-a_nr_reg) : a_nr_reg;
        ni_abs = a_ni_reg[64] ? 65'(-a_ni_reg) : a_ni_reg;
        mag_r  = nr_abs[63:0];
        mag_i  = ni_abs[63:0];

        b_side_next       = a_side_reg;
        b_side_next.dz    = (a_den_reg == 64'd0);
        b_side_next.neg_r = a_nr_reg[64];
        b_side_next.neg_i = a_ni_reg[64];
        // quotient needs more than 32 bits
        b_side_next.big_r = {8'd0, mag_r} >= {a_den_reg, 8'd0};
        b_side_next.big_i = {8'd0, mag_i} >= {a_den_reg, 8'd0};

        b_div_next.den    = a_den_reg;
        b_div_next.rem_r  = {8'd0, mag_r[63:FEED_W]};
        b_div_next.rem_i  = {8'd0, mag_i[63:FEED_W]};
        b_div_next.feed_r = mag_r[FEED_W-1:0];
        b_div_next.feed_i = mag_i[FEED_W-1:0];
        b_div_next.q_r    = '0;
        b_div_next.q_i    = '0;
    end

    assign a_ready = !b_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && a_ready) begin
            b_side_reg <= b_side_next;
            b_div_reg  <= b_div_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;
    assign out_div   = b_div_reg;

endmodule

/* rtl/cau_div_step.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider step
// One registered restoring-division step for the real and imaginary quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_div_step import cau_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  side_t in_side,
    input  divw_t in_div,
    output logic  out_valid,
    input  logic  out_ready,
    output side_t out_side,
    output divw_t out_div
);

    logic        valid_reg;
    side_t       side_reg;
    divw_t       div_reg, div_next;
    logic [64:0] tr, ti, dr, di;
    logic        ge_r, ge_i;

    always_comb begin
        tr   = {in_div.rem_r, in_div.feed_r[FEED_W-1]};
        ti   = {in_div.rem_i, in_div.feed_i[FEED_W-1]};
        ge_r = tr >= {1'b0, in_div.den};
        ge_i = ti >= {1'b0, in_div.den};
        dr   = tr - {1'b0, in_div.den};
        di   = ti - {1'b0, in_div.den};

        div_next.den    = in_div.den;
        div_next.rem_r  = ge_r ? dr[63:0] : tr[63:0];
        div_next.rem_i  = ge_i ? di[63:0] : ti[63:0];
        div_next.feed_r = in_div.feed_r << 1;
        div_next.feed_i = in_div.feed_i << 1;
        div_next.q_r    = {in_div.q_r[30:0], ge_r};
        div_next.q_i    = {in_div.q_i[30:0], ge_i};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

endmodule

/* rtl/cau_final.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit output stage
// Signs and saturates the quotients, selects the result and holds it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_final import cau_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  side_t              in_side,
    input  divw_t              in_div,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_real,
    output logic signed [31:0] res_imag,
    output logic               is_equal,
    output logic               div_zero,
    output logic               overflow
);

    logic               valid_reg;
    logic signed [31:0] rr_reg, rr_next, ri_reg, ri_next;
    logic               eq_reg, eq_next, dz_reg, dz_next, ovf_reg, ovf_next;
    logic               or_r, or_i;

    always_comb begin
        rr_next  = in_side.rr;
        ri_next  = in_side.ri;
        eq_next  = in_side.eq;
        dz_next  = 1'b0;
        ovf_next = in_side.ovf;
        or_r     = 1'b0;
        or_i     = 1'b0;
        if (in_side.cmd == CMD_DIV) begin
            eq_next = 1'b0;
            if (in_side.dz) begin
                rr_next  = '0;
                ri_next  = '0;
                dz_next  = 1'b1;
                ovf_next = 1'b0;
            end else begin
                // negative side may reach exactly the most negative word
                if (in_side.neg_r) begin
                    or_r    = in_side.big_r || (in_div.q_r > WORD_MIN);
                    rr_next = or_r ? WORD_MIN : 32'(-in_div.q_r);
                end else begin
                    or_r    = in_side.big_r || in_div.q_r[31];
                    rr_next = or_r ? WORD_MAX : in_div.q_r;
                end
                if (in_side.neg_i) begin
                    or_i    = in_side.big_i || (in_div.q_i > WORD_MIN);
                    ri_next = or_i ? WORD_MIN : 32'(-in_div.q_i);
                end else begin
                    or_i    = in_side.big_i || in_div.q_i[31];
                    ri_next = or_i ? WORD_MAX : in_div.q_i;
                end
                ovf_next = or_r || or_i;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_real  = rr_reg;
    assign res_imag  = ri_reg;
    assign is_equal  = eq_reg;
    assign div_zero  = dz_reg;
    assign overflow  = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rr_reg  <= rr_next;
            ri_reg  <= ri_next;
            eq_reg  <= eq_next;
            dz_reg  <= dz_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

/* rtl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined complex add, subtract, multiply, divide, negate, scale and compare.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: a command and two Q8.24 complex operands.
// One result per request leaves on the m_ stream in request order.
// The path has one multiply stage, two prepare stages, 32 divider steps
// (one quotient bit of both parts per stage) and the output register.
// Every command takes the same path, so order is kept without tags.
// Throughput is one request per cycle while m_tready is high; the 32-step
// divider pipeline sets the depth. Each stage has its own valid bit and
// loads when it is empty or its successor moves, so bubbles close up while
// m_tready is low and input is still taken until every stage is full.
// The tolerance register sits on the APB port at address 0; write it only
// when the pipeline is empty. Synchronous reset empties all stages and loads
// the tolerance with its default of 17.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[2:0], a_real[34:3], a_imag[66:35], b_real[98:67], b_imag[130:99]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_real[31:0], res_imag[63:32], is_equal[64], div_zero[65], overflow[66]
    output logic [71:0]  m_tdata
);

    logic [TOL_W-1:0] tol_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOL_IDX[0]) ? {1'b0, tol_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_TOL_IDX[0]) begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    logic s1_valid, s1_ready;
    s1_t  s1_data;

    cau_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (s_tdata[2:0]),
        .a_real    (s_tdata[34:3]),
        .a_imag    (s_tdata[66:35]),
        .b_real    (s_tdata[98:67]),
        .b_imag    (s_tdata[130:99]),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    logic  st_valid [0:DIV_STEPS];
    logic  st_ready [0:DIV_STEPS];
    side_t st_side  [0:DIV_STEPS];
    divw_t st_div   [0:DIV_STEPS];

    cau_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tol       (tol_reg),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_side  (st_side[0]),
        .out_div   (st_div[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        cau_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_side   (st_side[k]),
            .in_div    (st_div[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_side  (st_side[k+1]),
            .out_div   (st_div[k+1])
        );
    end

    logic signed [31:0] res_real, res_imag;
    logic               is_equal, div_zero, overflow;

    cau_final u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st_valid[DIV_STEPS]),
        .in_ready  (st_ready[DIV_STEPS]),
        .in_side   (st_side[DIV_STEPS]),
        .in_div    (st_div[DIV_STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_real  (res_real),
        .res_imag  (res_imag),
        .is_equal  (is_equal),
        .div_zero  (div_zero),
        .overflow  (overflow)
    );

    assign m_tdata = {5'd0, overflow, div_zero, is_equal, res_imag, res_real};

    `CAU_ASSERT_NOW(a_full_only_when_stalled, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input blocked without output stall")
    `CAU_ASSERT_NOW(a_div_zero_clean, aclk, aresetn, m_tvalid && div_zero, res_real == 32'sd0 && res_imag == 32'sd0 && !overflow && !is_equal, "divide by zero result not cleared")
    `CAU_ASSERT_NOW(a_equal_clean, aclk, aresetn, m_tvalid && is_equal, res_real == 32'sd0 && res_imag == 32'sd0 && !overflow && !div_zero, "equal result carries data")
    `CAU_ASSERT_NEXT(a_stall_holds_result, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "held result dropped")

endmodule
